[rtl/egp_pkg.sv]
`default_nettype none

package egp_pkg;

  // width of each coordinate field on the port
  localparam int FIELD_WIDTH = 16;
  // default working precision of the coordinates
  localparam int COORD_WIDTH_DEF = 16;

  typedef enum logic [1:0] {
    PRED_PLANAR   = 2'd0,
    PRED_SPATIAL  = 2'd1,
    PRED_INCIRCLE = 2'd2,
    PRED_NONE     = 2'd3
  } pred_t;

  // control travelling alongside the datapath
  typedef struct packed {
    logic  valid;
    pred_t sel;
  } ctl_t;

  typedef struct packed {
    logic signed [FIELD_WIDTH-1:0] point_a_x;
    logic signed [FIELD_WIDTH-1:0] point_a_y;
    logic signed [FIELD_WIDTH-1:0] point_a_z;
    logic signed [FIELD_WIDTH-1:0] point_b_x;
    logic signed [FIELD_WIDTH-1:0] point_b_y;
    logic signed [FIELD_WIDTH-1:0] point_b_z;
    logic signed [FIELD_WIDTH-1:0] point_c_x;
    logic signed [FIELD_WIDTH-1:0] point_c_y;
    logic signed [FIELD_WIDTH-1:0] point_c_z;
    logic signed [FIELD_WIDTH-1:0] point_d_x;
    logic signed [FIELD_WIDTH-1:0] point_d_y;
    logic signed [FIELD_WIDTH-1:0] point_d_z;
  } operands_t;

  typedef struct packed {
    logic signed [1:0]  exact_sign;
    logic signed [63:0] determinant_value;
    logic               value_saturated;
  } result_t;

  // slots of the coordinate difference vector
  localparam int D_ABX = 0;
  localparam int D_ABY = 1;
  localparam int D_ABZ = 2;
  localparam int D_ACX = 3;
  localparam int D_ACY = 4;
  localparam int D_ACZ = 5;
  localparam int D_ADX = 6;
  localparam int D_ADY = 7;
  localparam int D_ADZ = 8;
  localparam int D_BDX = 9;
  localparam int D_BDY = 10;
  localparam int D_CDX = 11;
  localparam int D_CDY = 12;
  localparam int D_BCX = 13;
  localparam int D_BCY = 14;
  localparam int NUM_DIFFS = 15;

  // number of small products formed in the second stage
  localparam int NUM_PRODS = 12;

endpackage

`default_nettype wire

[rtl/egp_diff.sv]
`default_nettype none

module egp_diff import egp_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire ctl_t                    ctl_in,
  input  wire operands_t               operands,
  output ctl_t                         ctl_out,
  output logic signed [COORD_WIDTH:0]  diff [NUM_DIFFS]
);

  localparam int DW = COORD_WIDTH + 1;

  logic signed [COORD_WIDTH-1:0] ax, ay, az, bx, by, bz, cx, cy, cz, dx, dy, dz;
  logic signed [DW-1:0]          diff_next [NUM_DIFFS];

  // bits above the working precision are dropped, narrower fields sign-extend
  assign ax = COORD_WIDTH'(operands.point_a_x);
  assign ay = COORD_WIDTH'(operands.point_a_y);
  assign az = COORD_WIDTH'(operands.point_a_z);
  assign bx = COORD_WIDTH'(operands.point_b_x);
  assign by = COORD_WIDTH'(operands.point_b_y);
  assign bz = COORD_WIDTH'(operands.point_b_z);
  assign cx = COORD_WIDTH'(operands.point_c_x);
  assign cy = COORD_WIDTH'(operands.point_c_y);
  assign cz = COORD_WIDTH'(operands.point_c_z);
  assign dx = COORD_WIDTH'(operands.point_d_x);
  assign dy = COORD_WIDTH'(operands.point_d_y);
  assign dz = COORD_WIDTH'(operands.point_d_z);

  always_comb begin
    diff_next[D_ABX] = DW'(ax) - DW'(bx);
    diff_next[D_ABY] = DW'(ay) - DW'(by);
    diff_next[D_ABZ] = DW'(az) - DW'(bz);
    diff_next[D_ACX] = DW'(ax) - DW'(cx);
    diff_next[D_ACY] = DW'(ay) - DW'(cy);
    diff_next[D_ACZ] = DW'(az) - DW'(cz);
    diff_next[D_ADX] = DW'(ax) - DW'(dx);
    diff_next[D_ADY] = DW'(ay) - DW'(dy);
    diff_next[D_ADZ] = DW'(az) - DW'(dz);
    diff_next[D_BDX] = DW'(bx) - DW'(dx);
    diff_next[D_BDY] = DW'(by) - DW'(dy);
    diff_next[D_CDX] = DW'(cx) - DW'(dx);
    diff_next[D_CDY] = DW'(cy) - DW'(dy);
    diff_next[D_BCX] = DW'(bx) - DW'(cx);
    diff_next[D_BCY] = DW'(by) - DW'(cy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    diff <= diff_next;
  end

endmodule

`default_nettype wire

[rtl/egp_prod.sv]
`default_nettype none

module egp_prod import egp_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire ctl_t                        ctl_in,
  input  wire logic signed [COORD_WIDTH:0] diff [NUM_DIFFS],
  output ctl_t                             ctl_out,
  output logic signed [2*COORD_WIDTH+2:0]  f_out [3],
  output logic signed [2*COORD_WIDTH+2:0]  g_out [3]
);

  localparam int DW = COORD_WIDTH + 1;
  localparam int MW = 2 * DW;
  localparam int OW = 2 * COORD_WIDTH + 3;

  logic signed [DW-1:0] opa [NUM_PRODS];
  logic signed [DW-1:0] opb [NUM_PRODS];
  logic signed [MW-1:0] prod [NUM_PRODS];
  logic signed [DW-1:0] ab [3];
  ctl_t                 ctl_mid;
  logic signed [OW-1:0] f_next [3];
  logic signed [OW-1:0] g_next [3];
  logic signed [OW-1:0] minor [3];
  logic signed [OW-1:0] lift [3];

  // operand routing per predicate
  always_comb begin
    for (int k = 0; k < NUM_PRODS; k++) begin
      opa[k] = '0;
      opb[k] = '0;
    end
    case (ctl_in.sel)
      PRED_PLANAR: begin
        opa[0] = diff[D_ACX]; opb[0] = diff[D_BCY];
        opa[1] = diff[D_ACY]; opb[1] = diff[D_BCX];
      end
      PRED_SPATIAL: begin
        opa[0] = diff[D_ACY]; opb[0] = diff[D_ADZ];
        opa[1] = diff[D_ACZ]; opb[1] = diff[D_ADY];
        opa[2] = diff[D_ACZ]; opb[2] = diff[D_ADX];
        opa[3] = diff[D_ACX]; opb[3] = diff[D_ADZ];
        opa[4] = diff[D_ACX]; opb[4] = diff[D_ADY];
        opa[5] = diff[D_ACY]; opb[5] = diff[D_ADX];
      end
      PRED_INCIRCLE: begin
        // cross terms of the shifted points
        opa[0] = diff[D_BDX]; opb[0] = diff[D_CDY];
        opa[1] = diff[D_BDY]; opb[1] = diff[D_CDX];
        opa[2] = diff[D_CDX]; opb[2] = diff[D_ADY];
        opa[3] = diff[D_CDY]; opb[3] = diff[D_ADX];
        opa[4] = diff[D_ADX]; opb[4] = diff[D_BDY];
        opa[5] = diff[D_ADY]; opb[5] = diff[D_BDX];
        // squares for the lifted coordinate
        opa[6]  = diff[D_ADX]; opb[6]  = diff[D_ADX];
        opa[7]  = diff[D_ADY]; opb[7]  = diff[D_ADY];
        opa[8]  = diff[D_BDX]; opb[8]  = diff[D_BDX];
        opa[9]  = diff[D_BDY]; opb[9]  = diff[D_BDY];
        opa[10] = diff[D_CDX]; opb[10] = diff[D_CDX];
        opa[11] = diff[D_CDY]; opb[11] = diff[D_CDY];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_PRODS; k++) begin
      prod[k] <= opa[k] * opb[k];
    end
    ab[0] <= diff[D_ABX];
    ab[1] <= diff[D_ABY];
    ab[2] <= diff[D_ABZ];
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      minor[i] = OW'(prod[2*i]) - OW'(prod[2*i+1]);
      lift[i]  = OW'(prod[6+2*i]) + OW'(prod[7+2*i]);
      f_next[i] = '0;
      g_next[i] = minor[i];
    end
    case (ctl_mid.sel)
      PRED_PLANAR: begin
        f_next[0] = {{(OW-1){1'b0}}, 1'b1};
      end
      PRED_SPATIAL: begin
        for (int i = 0; i < 3; i++) begin
          f_next[i] = OW'(ab[i]);
        end
      end
      PRED_INCIRCLE: begin
        for (int i = 0; i < 3; i++) begin
          f_next[i] = lift[i];
        end
      end
      default: begin
        for (int i = 0; i < 3; i++) begin
          g_next[i] = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    f_out <= f_next;
    g_out <= g_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_mid <= '0;
      ctl_out <= '0;
    end else begin
      ctl_mid <= ctl_in;
      ctl_out <= ctl_mid;
    end
  end

endmodule

`default_nettype wire

[rtl/egp_mult.sv]
`default_nettype none

module egp_mult import egp_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic signed [2*COORD_WIDTH+2:0]   f,
  input  wire logic signed [2*COORD_WIDTH+2:0]   g,
  output logic signed [4*COORD_WIDTH+5:0]        prod
);

  localparam int OW = 2 * COORD_WIDTH + 3;
  localparam int LW = OW / 2;
  localparam int HW = OW - LW;
  localparam int PW = 2 * OW;

  logic signed [HW-1:0]      fh, gh;
  logic signed [LW:0]        fl, gl;
  logic signed [2*HW-1:0]    pp_hh;
  logic signed [HW+LW:0]     pp_hl, pp_lh;
  logic signed [2*LW+1:0]    pp_ll;

  // split each operand into a signed upper half and an unsigned lower half
  assign fh = f[OW-1:LW];
  assign gh = g[OW-1:LW];
  assign fl = {1'b0, f[LW-1:0]};
  assign gl = {1'b0, g[LW-1:0]};

  always_ff @(posedge clk) begin
    pp_hh <= fh * gh;
    pp_hl <= fh * gl;
    pp_lh <= fl * gh;
    pp_ll <= fl * gl;
  end

  always_ff @(posedge clk) begin
    prod <= (PW'(pp_hh) <<< (2 * LW)) + (PW'(pp_hl) <<< LW)
          + (PW'(pp_lh) <<< LW) + PW'(pp_ll);
  end

endmodule

`default_nettype wire

[rtl/egp_accum.sv]
`default_nettype none

module egp_accum import egp_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire ctl_t                            ctl_in,
  input  wire logic signed [4*COORD_WIDTH+5:0] prod [3],
  output logic                                 done,
  output result_t                              result
);

  localparam int OW = 2 * COORD_WIDTH + 3;
  localparam int PW = 2 * OW;
  localparam int TW = PW + 2;
  localparam int SW = (TW > 64) ? TW : 64;

  localparam logic signed [63:0] SAT_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] SAT_MIN = {1'b1, {63{1'b0}}};

  logic signed [TW-1:0] total;
  logic                 total_valid;
  logic signed [SW-1:0] total_ext;
  logic                 negative;
  logic                 nonzero;
  logic                 fits;
  result_t              result_next;

  always_ff @(posedge clk) begin
    total <= TW'(prod[0]) + TW'(prod[1]) + TW'(prod[2]);
  end

  assign total_ext = SW'(total);
  assign negative  = total[TW-1];
  assign nonzero   = |total;
  // in range when every bit from 63 up copies the sign
  assign fits      = (total_ext[SW-1:63] == {(SW-63){total_ext[63]}});

  always_comb begin
    result_next.value_saturated = ~fits;
    if (negative) begin
      result_next.exact_sign = -2'sd1;
    end else if (nonzero) begin
      result_next.exact_sign = 2'sd1;
    end else begin
      result_next.exact_sign = 2'sd0;
    end
    if (fits) begin
      result_next.determinant_value = total_ext[63:0];
    end else if (negative) begin
      result_next.determinant_value = SAT_MIN;
    end else begin
      result_next.determinant_value = SAT_MAX;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total_valid <= 1'b0;
      done        <= 1'b0;
    end else begin
      total_valid <= ctl_in.valid;
      done        <= total_valid;
    end
  end

endmodule

`default_nettype wire

[rtl/exact_geometric_predicates_unit.sv]
// pipeline: each start beat passes through seven register stages in all; done is
//   raised together with the registered result of that beat
// throughput: one beat per cycle, busy is never raised; the results follow the
//   order of the start beats, and the receiver cannot stall them
// reset: synchronous rst clears every stage valid and sets predicate_select to 0
`default_nettype none

module exact_geometric_predicates_unit import egp_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  // configuration: predicate select register
  input  wire logic      cfg_write,
  input  wire logic [1:0] cfg_data,
  // command side
  input  wire logic      start,
  output logic           busy,
  input  wire operands_t operands,
  // result side, one strobe per beat
  output logic           done,
  output result_t        result
);

  localparam int OW = 2 * COORD_WIDTH + 3;
  localparam int PW = 2 * OW;

  // pipeline plan
  //   stage 1  coordinate differences
  //   stage 2  twelve small products, routed per predicate
  //   stage 3  minors / lifted terms, giving three operand pairs f*g
  //   stage 4  partial products of each pair (split in halves)
  //   stage 5  pair products recombined
  //   stage 6  sum of the three pair products
  //   stage 7  sign, saturation and output register

  pred_t                   sel;
  ctl_t                    ctl_in;
  ctl_t                    ctl_s1;
  ctl_t                    ctl_s3;
  ctl_t                    ctl_s4;
  ctl_t                    ctl_s5;
  logic signed [COORD_WIDTH:0] diff [NUM_DIFFS];
  logic signed [OW-1:0]    f_op [3];
  logic signed [OW-1:0]    g_op [3];
  logic signed [PW-1:0]    pair_prod [3];

  // the pipeline never holds off a beat
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      sel <= PRED_PLANAR;
    end else if (cfg_write) begin
      sel <= pred_t'(cfg_data);
    end
  end

  // the select rides with each beat so a later write cannot disturb it
  assign ctl_in.valid = start & ~busy;
  assign ctl_in.sel   = sel;

  egp_diff #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_diff (
    .clk      (clk),
    .rst      (rst),
    .ctl_in   (ctl_in),
    .operands (operands),
    .ctl_out  (ctl_s1),
    .diff     (diff)
  );

  egp_prod #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_prod (
    .clk     (clk),
    .rst     (rst),
    .ctl_in  (ctl_s1),
    .diff    (diff),
    .ctl_out (ctl_s3),
    .f_out   (f_op),
    .g_out   (g_op)
  );

  // three wide multipliers, one per term of the determinant expansion
  for (genvar i = 0; i < 3; i++) begin : g_pair
    egp_mult #(
      .COORD_WIDTH (COORD_WIDTH)
    ) u_mult (
      .clk  (clk),
      .f    (f_op[i]),
      .g    (g_op[i]),
      .prod (pair_prod[i])
    );
  end

  // control follows the two multiplier stages
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_s4 <= '0;
      ctl_s5 <= '0;
    end else begin
      ctl_s4 <= ctl_s3;
      ctl_s5 <= ctl_s4;
    end
  end

  egp_accum #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_accum (
    .clk    (clk),
    .rst    (rst),
    .ctl_in (ctl_s5),
    .prod   (pair_prod),
    .done   (done),
    .result (result)
  );

endmodule

`default_nettype wire
